// ===== src/upf_pkg.sv =====
// ----------------------------------------------------------------------------
// upf_pkg
// Shared types, constants and decode helpers for the UTF-8 range filter.
// ----------------------------------------------------------------------------
package upf_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned SlotN  = 4;
  localparam int unsigned HeldN  = 3;
  localparam int unsigned LenW   = 3;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned QueueDepth = 4;

  localparam logic [CpW-1:0] DropLowRst  = 21'h00E000;
  localparam logic [CpW-1:0] DropHighRst = 21'h00F8FF;

  localparam logic [IdxW-1:0] RegDropLow  = 2'd0;
  localparam logic [IdxW-1:0] RegDropHigh = 2'd1;

  typedef logic [SlotN-1:0][ByteW-1:0] upf_window_t;

  // one classified input byte with the bytes it releases
  typedef struct packed {
    upf_window_t      data;
    logic [SlotN-1:0] keep;
    logic             str_end;
  } upf_entry_t;

  // sequence length announced by a lead byte, 0 for a stray byte
  function automatic logic [LenW-1:0] lead_len(input logic [ByteW-1:0] c);
    logic [LenW-1:0] len;
    if (!c[7]) begin
      len = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

  // code point of the sequence starting at s[0]
  function automatic logic [CpW-1:0] decode_cp(input upf_window_t s,
                                                input logic [LenW-1:0] len);
    logic [CpW-1:0] cp;
    unique case (len)
      3'd1: cp = {13'd0, s[0]};
      3'd2: cp = {10'd0, s[0][4:0], s[1][5:0]};
      3'd3: cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
      3'd4: cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
      default: cp = '0;
    endcase
    return cp;
  endfunction

endpackage

// ===== src/utf8_private_use_filter.sv =====
// ----------------------------------------------------------------------------
// utf8_private_use_filter
// UTF-8 byte stream filter that removes sequences whose code point lies in a
// configurable range.
// ----------------------------------------------------------------------------
// Input channel: one raw byte per transfer, in_last_i on the final byte of a
// string. Output channel: filtered bytes, byte_valid_o low on a bare end
// marker, string_end_o on the last result of a string, run_last_o on the last
// result caused by one input byte.
// Path: the first result of an input byte passes through the queue, the
// emitter's current entry register and the output register. Throughput: one
// input byte per cycle while each byte gives at most one result and the queue
// has room; a byte that releases a whole sequence holds the output until each
// surviving byte is sent, and bytes that give no result use the input only.
// A queue of QueueDepth entries sits between the classifier and the output
// stage; when the receiver stalls the queue fills and in_ready_o drops.
// Reset clears the open sequence, empties the queue and loads the drop range
// with E000 to F8FF. Range writes on the configuration port take effect on
// the next cycle.
// ----------------------------------------------------------------------------
module utf8_private_use_filter #(
  parameter int unsigned QueueDepth = upf_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [upf_pkg::ByteW-1:0] in_byte_i,
  input  logic                      in_last_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [upf_pkg::ByteW-1:0] out_byte_o,
  output logic                      byte_valid_o,
  output logic                      string_end_o,
  output logic                      run_last_o,
  input  logic                      cfg_we_i,
  input  logic [upf_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [upf_pkg::CpW-1:0]   cfg_wdata_i
);

  upf_pkg::upf_entry_t push_entry, head_entry;
  logic                push, full, pop, empty;

  upf_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .full_i      (full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  upf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_entry)
  );

  upf_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_entry),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .string_end_o (string_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

// ===== src/upf_classify.sv =====
// ----------------------------------------------------------------------------
// upf_classify
// Front end: takes input bytes, tracks the open sequence, decodes complete
// sequences and marks which bytes survive the drop range.
// ----------------------------------------------------------------------------
module upf_classify (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [upf_pkg::ByteW-1:0]          in_byte_i,
  input  logic                               in_last_i,
  input  logic                               cfg_we_i,
  input  logic [upf_pkg::IdxW-1:0]           cfg_idx_i,
  input  logic [upf_pkg::CpW-1:0]            cfg_wdata_i,
  input  logic                               full_i,
  output logic                               push_o,
  output upf_pkg::upf_entry_t                entry_o
);

  localparam int unsigned SlotN = upf_pkg::SlotN;

  logic [upf_pkg::CpW-1:0]                       drop_low_q, drop_high_q;
  logic [upf_pkg::HeldN-1:0][upf_pkg::ByteW-1:0] held_q;
  logic [1:0]                                    held_cnt_q, held_cnt_d;
  logic [upf_pkg::LenW-1:0]                      seq_len_q, seq_len_d;

  upf_pkg::upf_window_t     buf_w;
  upf_pkg::upf_window_t     win;
  logic [upf_pkg::LenW-1:0] fill;
  logic [upf_pkg::LenW-1:0] in_len;
  logic                     complete;
  logic                     accept;
  logic                     hold_lead, hold_next;
  logic [upf_pkg::LenW-1:0] seg_len [SlotN];
  logic [3:0]               seg_end [SlotN];
  logic                     seg_fit [SlotN];
  logic                     seg_drop [SlotN];
  logic [upf_pkg::CpW-1:0]  seg_cp;
  logic [3:0]               next_pos;
  logic [SlotN-1:0]         keep;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    buf_w = {8'h00, held_q};
    buf_w[held_cnt_q] = in_byte_i;
  end

  assign fill     = {1'b0, held_cnt_q} + 3'd1;
  assign in_len   = upf_pkg::lead_len(in_byte_i);
  assign complete = (seq_len_q == '0) ? (in_len == 3'd1) : (fill >= seq_len_q);

  // candidate sequence at every slot
  always_comb begin
    for (int i = 0; i < SlotN; i++) begin
      win         = buf_w >> (i * upf_pkg::ByteW);
      seg_len[i]  = upf_pkg::lead_len(win[0]);
      seg_end[i]  = 4'(i) + {1'b0, seg_len[i]};
      seg_fit[i]  = (seg_len[i] != '0) && (seg_end[i] <= {1'b0, fill});
      seg_cp      = upf_pkg::decode_cp(win, seg_len[i]);
      seg_drop[i] = (seg_cp >= drop_low_q) && (seg_cp <= drop_high_q);
    end
  end

  // walk the buffer, skipping leads whose sequence does not fit
  always_comb begin
    next_pos = '0;
    keep     = '0;
    for (int i = 0; i < SlotN; i++) begin
      if ((4'(i) == next_pos) && (3'(i) < fill)) begin
        if (seg_fit[i]) begin
          for (int j = 0; j < SlotN; j++) begin
            if ((j >= i) && (4'(j) < seg_end[i])) begin
              keep[j] = !seg_drop[i];
            end
          end
          next_pos = seg_end[i];
        end else begin
          next_pos = next_pos + 4'd1;
        end
      end
    end
  end

  assign push_o = accept && (in_last_i || (complete && (keep != '0)));

  always_comb begin
    entry_o.data    = buf_w;
    entry_o.keep    = keep;
    entry_o.str_end = in_last_i;
  end

  assign hold_lead = !in_last_i && (seq_len_q == '0) && (in_len >= 3'd2);
  assign hold_next = !in_last_i && (seq_len_q != '0) && !complete;

  always_comb begin
    held_cnt_d = '0;
    seq_len_d  = '0;
    if (hold_lead) begin
      held_cnt_d = 2'd1;
      seq_len_d  = in_len;
    end else if (hold_next) begin
      held_cnt_d = fill[1:0];
      seq_len_d  = seq_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_low_q  <= upf_pkg::DropLowRst;
      drop_high_q <= upf_pkg::DropHighRst;
      held_cnt_q  <= '0;
      seq_len_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          upf_pkg::RegDropLow:  drop_low_q  <= cfg_wdata_i;
          upf_pkg::RegDropHigh: drop_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (accept) begin
        held_cnt_q <= held_cnt_d;
        seq_len_q  <= seq_len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_lead) begin
      held_q[0] <= in_byte_i;
    end else if (accept && hold_next) begin
      held_q[held_cnt_q] <= in_byte_i;
    end
  end

endmodule

// ===== src/upf_queue.sv =====
// ----------------------------------------------------------------------------
// upf_queue
// Short first-in first-out queue of classified entries between the front end
// and the emitter.
// ----------------------------------------------------------------------------
module upf_queue #(
  parameter int unsigned Depth = upf_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  upf_pkg::upf_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output upf_pkg::upf_entry_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  upf_pkg::upf_entry_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== src/upf_emit.sv =====
// ----------------------------------------------------------------------------
// upf_emit
// Back end: takes one queued entry at a time and sends its surviving bytes or a
// bare end marker through an output register, one transfer per cycle unless stalled.
// ----------------------------------------------------------------------------
module upf_emit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  upf_pkg::upf_entry_t       head_i,
  input  logic                      empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [upf_pkg::ByteW-1:0] out_byte_o,
  output logic                      byte_valid_o,
  output logic                      string_end_o,
  output logic                      run_last_o
);

  localparam int unsigned SlotN = upf_pkg::SlotN;

  logic                      cur_valid_q;
  upf_pkg::upf_window_t      cur_data_q;
  logic [SlotN-1:0]          cur_keep_q;
  logic                      cur_end_q;
  logic                      out_valid_q;
  logic [upf_pkg::ByteW-1:0] out_byte_q;
  logic                      byte_valid_q, string_end_q, run_last_q;

  logic                      advance;
  logic [1:0]                sel;
  logic [SlotN-1:0]          rest;
  logic                      final_res;

  assign advance = cur_valid_q && (!out_valid_q || out_ready_i);

  always_comb begin
    sel = '0;
    for (int i = SlotN - 1; i >= 0; i--) begin
      if (cur_keep_q[i]) begin
        sel = 2'(i);
      end
    end
  end

  assign rest      = cur_keep_q & ~(4'b0001 << sel);
  assign final_res = (rest == '0);
  assign pop_o     = !empty_i && (!cur_valid_q || (advance && final_res));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (advance && final_res) begin
        cur_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_data_q <= head_i.data;
      cur_keep_q <= head_i.keep;
      cur_end_q  <= head_i.str_end;
    end else if (advance) begin
      cur_keep_q <= rest;
    end
    if (advance) begin
      out_byte_q   <= (cur_keep_q == '0) ? '0 : cur_data_q[sel];
      byte_valid_q <= (cur_keep_q != '0);
      run_last_q   <= final_res;
      string_end_q <= final_res && cur_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign string_end_o = string_end_q;
  assign run_last_o   = run_last_q;

  // bare end marker closes both the string and the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> string_end_o && run_last_o)
    else $error("bare marker without end flags");

  // string end only on the last result of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end before run end");

  // an entry that is not a string end always carries a byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q && !cur_end_q |-> cur_keep_q != '0)
    else $error("empty entry held in emitter");

  // a stalled result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_byte_q) && $stable(run_last_q))
    else $error("stalled result changed");

endmodule

// ===== sim/utf8_private_use_filter_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_private_use_filter_tb
// Self-checking bench for the UTF-8 code point range filter. Byte strings go
// in on a valid/ready channel and every filtered result is compared with a
// behavioral model of the filter. Stimulus covers fixed cases, several drop
// ranges, a long output stall and randomized strings under varying idle rates.
// ----------------------------------------------------------------------------
module utf8_private_use_filter_tb;

  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned RunLimitNs   = 1_000_000;
  localparam int unsigned CpMax        = 21'h1FFFFF;
  localparam logic [upf_pkg::IdxW-1:0] RegSpare2 = 2'd2;
  localparam logic [upf_pkg::IdxW-1:0] RegSpare3 = 2'd3;

  typedef struct packed {
    logic [upf_pkg::ByteW-1:0] data;
    logic                      has_data;
    logic                      str_end;
    logic                      run_end;
  } filt_out_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [upf_pkg::ByteW-1:0] in_byte_i;
  logic                      in_last_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [upf_pkg::ByteW-1:0] out_byte_o;
  logic                      byte_valid_o;
  logic                      string_end_o;
  logic                      run_last_o;
  logic                      cfg_we_i;
  logic [upf_pkg::IdxW-1:0]  cfg_idx_i;
  logic [upf_pkg::CpW-1:0]   cfg_wdata_i;

  // filter model state
  logic [upf_pkg::ByteW-1:0] open_seq [upf_pkg::HeldN];
  int unsigned               open_cnt;
  int unsigned               open_len;
  logic [upf_pkg::CpW-1:0]   range_lo;
  logic [upf_pkg::CpW-1:0]   range_hi;

  filt_out_t                 filtered_q [$];
  filt_out_t                 step_out [$];
  logic [upf_pkg::ByteW-1:0] str_bytes [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_hold;
  int unsigned mismatch_count;

  utf8_private_use_filter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .in_last_i    (in_last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .string_end_o (string_end_o),
    .run_last_o   (run_last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #RunLimitNs;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int unsigned seq_len_of(input logic [upf_pkg::ByteW-1:0] c);
    casez (c)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  function automatic logic [upf_pkg::CpW-1:0] code_point(input upf_pkg::upf_window_t s,
                                                         input int unsigned first,
                                                         input int unsigned len);
    logic [upf_pkg::CpW-1:0] cp;
    case (len)
      1:       cp = upf_pkg::CpW'(s[first]);
      2:       cp = upf_pkg::CpW'(s[first][4:0]);
      3:       cp = upf_pkg::CpW'(s[first][3:0]);
      default: cp = upf_pkg::CpW'(s[first][2:0]);
    endcase
    for (int k = 1; k < len; k++) cp = {cp[upf_pkg::CpW-7:0], s[first+k][5:0]};
    return cp;
  endfunction

  task automatic emit_seq(input upf_pkg::upf_window_t s,
                          input int unsigned first, input int unsigned len);
    logic [upf_pkg::CpW-1:0] cp;
    filt_out_t               r;
    cp = code_point(s, first, len);
    if (cp >= range_lo && cp <= range_hi) return;
    for (int k = 0; k < len; k++) begin
      r = '0;
      r.data = s[first+k];
      r.has_data = 1'b1;
      step_out.push_back(r);
    end
  endtask

  task automatic close_seq();
    for (int k = 0; k < upf_pkg::HeldN; k++) open_seq[k] = '0;
    open_cnt = 0;
    open_len = 0;
  endtask

  // expected results of one accepted byte
  task automatic apply_filter(input logic [upf_pkg::ByteW-1:0] b, input logic last);
    upf_pkg::upf_window_t win;
    int unsigned          cnt;
    int unsigned          i;
    int unsigned          len;
    filt_out_t            tail;
    step_out.delete();
    win = '0;
    for (int k = 0; k < upf_pkg::HeldN; k++) win[k] = open_seq[k];
    cnt = open_cnt;
    win[cnt] = b;
    cnt++;
    if (last) begin
      i = 0;
      while (i < cnt) begin
        len = seq_len_of(win[i]);
        if (len == 0 || i + len > cnt) begin
          i++;
        end else begin
          emit_seq(win, i, len);
          i += len;
        end
      end
      close_seq();
      if (step_out.size() == 0) step_out.push_back('0);
      tail = step_out.pop_back();
      tail.str_end = 1'b1;
      step_out.push_back(tail);
    end else if (open_len == 0) begin
      len = seq_len_of(b);
      if (len == 1) begin
        emit_seq(win, 0, 1);
      end else if (len >= 2) begin
        open_seq[0] = b;
        open_cnt = 1;
        open_len = len;
      end
    end else if (cnt >= open_len) begin
      emit_seq(win, 0, open_len);
      close_seq();
    end else begin
      open_seq[open_cnt] = b;
      open_cnt = cnt;
    end
    if (step_out.size() != 0) begin
      tail = step_out.pop_back();
      tail.run_end = 1'b1;
      step_out.push_back(tail);
    end
    foreach (step_out[k]) filtered_q.push_back(step_out[k]);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t: %s got %0h want %0h", $time, what, got, want);
  endtask

  // output checker
  always @(posedge clk_i) begin
    filt_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (filtered_q.size() == 0) begin
        report_mismatch("unexpected transfer, byte", out_byte_o, 0);
      end else begin
        want = filtered_q.pop_front();
        if (out_byte_o !== want.data) report_mismatch("out_byte", out_byte_o, want.data);
        if (byte_valid_o !== want.has_data)
          report_mismatch("byte_valid", byte_valid_o, want.has_data);
        if (string_end_o !== want.str_end)
          report_mismatch("string_end", string_end_o, want.str_end);
        if (run_last_o !== want.run_end)
          report_mismatch("run_last", run_last_o, want.run_end);
      end
    end
  end

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (recv_hold != 0) begin
      out_ready_i <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  task automatic send_byte(input logic [upf_pkg::ByteW-1:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    apply_filter(b, last);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [upf_pkg::IdxW-1:0] idx,
                           input logic [upf_pkg::CpW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      upf_pkg::RegDropLow:  range_lo = value;
      upf_pkg::RegDropHigh: range_hi = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int unsigned min_len(input logic [upf_pkg::CpW-1:0] cp);
    if (cp < 21'h80) return 1;
    if (cp < 21'h800) return 2;
    if (cp < 21'h10000) return 3;
    return 4;
  endfunction

  // code points cluster around the drop range edges, fall inside the range or spread by length
  function automatic logic [upf_pkg::CpW-1:0] pick_code_point();
    int v;
    case ($urandom_range(3))
      0: v = int'(range_lo) + int'($urandom_range(4)) - 2;
      1: v = int'(range_hi) + int'($urandom_range(4)) - 2;
      2: v = (range_lo <= range_hi) ? int'($urandom_range(range_hi, range_lo))
                                    : int'($urandom_range(CpMax));
      default: begin
        case ($urandom_range(3))
          0: v = int'($urandom_range(21'h7F));
          1: v = int'($urandom_range(21'h7FF));
          2: v = int'($urandom_range(21'hFFFF));
          default: v = int'($urandom_range(CpMax));
        endcase
      end
    endcase
    if (v < 0) v = 0;
    if (v > int'(CpMax)) v = int'(CpMax);
    return v[upf_pkg::CpW-1:0];
  endfunction

  task automatic push_code_point(input logic [upf_pkg::CpW-1:0] cp, input int unsigned len);
    case (len)
      1: str_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        str_bytes.push_back({3'b110, cp[10:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, cp[15:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, cp[20:18]});
        str_bytes.push_back({2'b10, cp[17:12]});
        str_bytes.push_back({2'b10, cp[11:6]});
        str_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic append_char(inout int unsigned useful);
    int unsigned               kind;
    int unsigned               len;
    logic [upf_pkg::CpW-1:0]   cp;
    logic [upf_pkg::ByteW-1:0] lead;
    kind = $urandom_range(99);
    if (kind < 70) begin
      cp = pick_code_point();
      len = min_len(cp);
      if ($urandom_range(9) == 0) len = $urandom_range(4, len);
      push_code_point(cp, len);
      useful += len;
    end else if (kind < 80) begin
      // stray byte
      if ($urandom_range(1)) str_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      else str_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
    end else if (kind < 90) begin
      // lead followed by arbitrary bytes in continuation position
      lead = 8'($urandom_range(8'hF7, 8'hC0));
      str_bytes.push_back(lead);
      repeat (seq_len_of(lead) - 1) str_bytes.push_back(8'($urandom_range(8'hFF)));
      useful += seq_len_of(lead);
    end else begin
      // cut-off sequence with one or more of its tail bytes removed
      cp = pick_code_point();
      len = (min_len(cp) < 2) ? 2 : min_len(cp);
      push_code_point(cp, len);
      repeat ($urandom_range(len - 1, 1)) void'(str_bytes.pop_back());
      useful += 1;
    end
  endtask

  task automatic send_random_string(output int unsigned useful);
    useful = 0;
    str_bytes.delete();
    repeat ($urandom_range(6, 1)) append_char(useful);
    if ($urandom_range(5) == 0)
      repeat ($urandom_range(2, 1)) if (str_bytes.size() > 1) void'(str_bytes.pop_back());
    foreach (str_bytes[k]) send_byte(str_bytes[k], k == str_bytes.size() - 1);
  endtask

  task automatic send_strings(input int unsigned n_useful);
    int unsigned done;
    int unsigned got;
    done = 0;
    while (done < n_useful) begin
      send_random_string(got);
      done += got;
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    // first code point of the default range, then one just above its end
    send_byte(8'hEE, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hA4, 1'b0);
    send_byte(8'h80, 1'b0);
    // stray bytes, then a four-byte sequence
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // string cut inside a sequence
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    // string of a single stray byte gives a bare end marker
    send_byte(8'hBF, 1'b1);
    // last code point of the default range, dropped, so a bare end marker
    send_byte(8'hEF, 1'b0);
    send_byte(8'hA3, 1'b0);
    send_byte(8'hBF, 1'b1);
    wait_drained();
  endtask

  task automatic run_range(input logic [upf_pkg::CpW-1:0] lo,
                           input logic [upf_pkg::CpW-1:0] hi);
    write_reg(upf_pkg::RegDropLow, lo);
    write_reg(upf_pkg::RegDropHigh, hi);
    send_strings(1);
    wait_drained();
  endtask

  task automatic test_range_settings();
    run_range(21'h000000, CpMax);
    run_range(CpMax, 21'h000000);
    run_range(21'h000041, 21'h000041);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_drained();
    run_range(21'h000080, 21'h0007FF);
    run_range(21'h110000, CpMax);
    run_range(21'($urandom_range(CpMax)), 21'($urandom_range(CpMax)));
    // unused indexes must leave the range alone
    write_reg(RegSpare2, CpMax);
    write_reg(RegSpare3, 21'h000000);
    send_strings(1);
    wait_drained();
    run_range(upf_pkg::DropLowRst, upf_pkg::DropHighRst);
  endtask

  task automatic test_backpressure();
    set_idle(0, 0);
    recv_hold <= 300;
    @(posedge clk_i);
    for (int k = 0; k < 12; k++) send_byte(8'($urandom_range(8'h7E, 8'h20)), k == 11);
    // sender pauses until the output side has caught up
    wait_drained();
  endtask

  task automatic test_random_traffic();
    set_idle(19, 57);
    @(posedge clk_i);
    write_reg(upf_pkg::RegDropLow, upf_pkg::DropLowRst);
    write_reg(upf_pkg::RegDropHigh, upf_pkg::DropHighRst);
    send_strings(3);
    wait_drained();
    set_idle(57, 19);
    write_reg(upf_pkg::RegDropLow, 21'($urandom_range(21'h10FFFF)));
    write_reg(upf_pkg::RegDropHigh, range_lo + 21'($urandom_range(21'h3FF)));
    send_strings(3);
    wait_drained();
    set_idle(0, 0);
    write_reg(upf_pkg::RegDropLow, 21'($urandom_range(CpMax)));
    write_reg(upf_pkg::RegDropHigh, 21'($urandom_range(CpMax)));
    send_strings(3);
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_byte_i = '0;
    in_last_i = 1'b0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = upf_pkg::RegDropLow;
    cfg_wdata_i = '0;
    send_idle_pct = 19;
    recv_idle_pct = 57;
    recv_hold = 0;
    mismatch_count = 0;
    range_lo = upf_pkg::DropLowRst;
    range_hi = upf_pkg::DropHighRst;
    close_seq();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_range_settings();
    test_backpressure();
    test_random_traffic();

    in_valid_i <= 1'b0;
    for (int k = 0; k < DrainLimit && filtered_q.size() != 0; k++) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (filtered_q.size() != 0) report_mismatch("results missing", filtered_q.size(), 0);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== utf8_private_use_filter.f =====
src/upf_pkg.sv
src/upf_classify.sv
src/upf_queue.sv
src/upf_emit.sv
src/utf8_private_use_filter.sv
sim/utf8_private_use_filter_tb.sv
